// ----- rtl/core/rpdma_pkg.sv -----
// ----------------------------------------------------------------------------
// rpdma_pkg
// Shared types and codes for the register programmed DMA copier.
// ----------------------------------------------------------------------------
package rpdma_pkg;

  localparam logic [1:0] OP_REG_WRITE = 2'd0;
  localparam logic [1:0] OP_TICK      = 2'd1;
  localparam logic [1:0] OP_READ_DATA = 2'd2;

  localparam logic [31:0] OFS_SOURCE = 32'h0000_0000;
  localparam logic [31:0] OFS_TARGET = 32'h0000_0004;
  localparam logic [31:0] OFS_COUNT  = 32'h0000_0008;
  localparam logic [31:0] OFS_START  = 32'h0000_000C;

  localparam logic [1:0] PHASE_READ  = 2'd0;
  localparam logic [1:0] PHASE_WRITE = 2'd1;

  localparam logic [31:0] WORD_BYTES = 32'd4;
  localparam logic [2:0]  FULL_LEN   = 3'd4;

  typedef struct packed {
    logic        request_valid;
    logic        request_is_write;
    logic [31:0] request_address;
    logic [31:0] request_data;
    logic [2:0]  request_length;
    logic        interrupt_level;
  } rslt_t;

endpackage

// ----- rtl/core/register_programmed_dma_copier.sv -----
// ----------------------------------------------------------------------------
// register_programmed_dma_copier
// Single-channel DMA engine programmed through a four-register window.
//
//   channel | direction | handshake           | content
//   in_     | input     | in_valid/in_stall   | bus write, tick or read data
//   out_    | output    | out_valid/out_stall | master request and irq level
//   cfg_    | input     | cfg_write_enable    | register window base address
//
// One word per cycle sustained while out_stall stays low; each word sees one
// register update (one offset subtractor and the pointer adders) and its
// result is registered. A two-entry output buffer (output register plus
// skid) lets a word enter while a result waits; in_stall rises only when
// both are full. Synchronous active-low reset clears all engine state.
// ----------------------------------------------------------------------------
module register_programmed_dma_copier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_enable,
  input  logic [31:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_bus_address,
  input  logic [31:0] in_write_value,
  input  logic [31:0] in_read_data,
  input  logic        in_soft_reset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_request_valid,
  output logic        out_request_is_write,
  output logic [31:0] out_request_address,
  output logic [31:0] out_request_data,
  output logic [2:0]  out_request_length,
  output logic        out_interrupt_level
);

  logic [31:0] base_r;
  logic [31:0] src_r, src_nxt;
  logic [31:0] tgt_r, tgt_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic        start_r, start_nxt;
  logic        irq_r, irq_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] held_r, held_nxt;

  rpdma_pkg::rslt_t res;
  rpdma_pkg::rslt_t out_r, skid_r;
  logic             out_valid_r, skid_valid_r;

  logic        accept;
  logic        take;
  logic [31:0] offset;

  assign accept = in_valid && !skid_valid_r;
  assign take   = out_valid_r && !out_stall;
  assign offset = in_bus_address - base_r;

  always_comb begin
    src_nxt   = src_r;
    tgt_nxt   = tgt_r;
    cnt_nxt   = cnt_r;
    start_nxt = start_r;
    irq_nxt   = irq_r;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    res       = '0;
    unique case (in_opcode)
      rpdma_pkg::OP_REG_WRITE: begin
        if (offset == rpdma_pkg::OFS_SOURCE) begin
          src_nxt = in_write_value;
        end else if (offset == rpdma_pkg::OFS_TARGET) begin
          tgt_nxt = in_write_value;
        end else if (offset == rpdma_pkg::OFS_COUNT) begin
          cnt_nxt = in_write_value;
        end else if (offset == rpdma_pkg::OFS_START) begin
          start_nxt = (in_write_value == 32'd1);
        end
      end
      rpdma_pkg::OP_TICK: begin
        if (in_soft_reset) begin
          src_nxt   = '0;
          tgt_nxt   = '0;
          cnt_nxt   = '0;
          start_nxt = 1'b0;
          irq_nxt   = 1'b0;
        end
        if (irq_nxt && !start_nxt) begin
          irq_nxt = 1'b0;
        end
        if (start_nxt && !irq_nxt) begin
          res.request_valid = 1'b1;
          if (phase_r == rpdma_pkg::PHASE_READ) begin
            res.request_address = src_nxt;
            res.request_length  = rpdma_pkg::FULL_LEN;
            phase_nxt           = rpdma_pkg::PHASE_WRITE;
          end else begin
            res.request_is_write = 1'b1;
            res.request_address  = tgt_nxt;
            res.request_data     = held_r;
            res.request_length   = (cnt_nxt >= 32'd1 && cnt_nxt <= 32'd3) ?
                                   cnt_nxt[2:0] : rpdma_pkg::FULL_LEN;
            if (cnt_nxt > rpdma_pkg::WORD_BYTES) begin
              src_nxt = src_nxt + rpdma_pkg::WORD_BYTES;
              tgt_nxt = tgt_nxt + rpdma_pkg::WORD_BYTES;
              cnt_nxt = cnt_nxt - rpdma_pkg::WORD_BYTES;
            end else begin
              src_nxt = '0;
              tgt_nxt = '0;
              cnt_nxt = '0;
              irq_nxt = 1'b1;
            end
            phase_nxt = rpdma_pkg::PHASE_READ;
          end
        end
      end
      rpdma_pkg::OP_READ_DATA: begin
        held_nxt = in_read_data;
      end
      default: begin
      end
    endcase
    res.interrupt_level = irq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      src_r   <= '0;
      tgt_r   <= '0;
      cnt_r   <= '0;
      start_r <= 1'b0;
      irq_r   <= 1'b0;
      phase_r <= rpdma_pkg::PHASE_READ;
      held_r  <= '0;
    end else begin
      if (cfg_write_enable) begin
        base_r <= cfg_write_data;
      end
      if (accept) begin
        src_r   <= src_nxt;
        tgt_r   <= tgt_nxt;
        cnt_r   <= cnt_nxt;
        start_r <= start_nxt;
        irq_r   <= irq_nxt;
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      if (out_valid_r) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= res;
      end
    end else if (accept) begin
      if (out_valid_r) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign in_stall             = skid_valid_r;
  assign out_valid            = out_valid_r;
  assign out_request_valid    = out_r.request_valid;
  assign out_request_is_write = out_r.request_is_write;
  assign out_request_address  = out_r.request_address;
  assign out_request_data     = out_r.request_data;
  assign out_request_length   = out_r.request_length;
  assign out_interrupt_level  = out_r.interrupt_level;

endmodule

// ----- rtl/core/rpdma_checker.sv -----
// ----------------------------------------------------------------------------
// rpdma_checker
// Port-level checks on the DMA copier, bound to the top level.
// ----------------------------------------------------------------------------
module rpdma_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_request_valid,
  input logic        out_request_is_write,
  input logic [31:0] out_request_address,
  input logic [31:0] out_request_data,
  input logic [2:0]  out_request_length
);

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_request_valid) |->
      (!out_request_is_write && out_request_address == 32'd0 &&
       out_request_data == 32'd0 && out_request_length == 3'd0))
    else $error("no request but fields not cleared");

  a_read_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_request_valid && !out_request_is_write) |->
      (out_request_length == 3'd4 && out_request_data == 32'd0))
    else $error("read request with bad length or data");

  a_write_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_request_valid && out_request_is_write) |->
      (out_request_length != 3'd0 && out_request_length <= 3'd4))
    else $error("write request length out of range");

  a_stalled_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_request_address) && $stable(out_request_data)))
    else $error("stalled result changed");

endmodule

bind register_programmed_dma_copier rpdma_checker u_rpdma_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_request_valid    (out_request_valid),
  .out_request_is_write (out_request_is_write),
  .out_request_address  (out_request_address),
  .out_request_data     (out_request_data),
  .out_request_length   (out_request_length)
);
